// ----- rtl/small_matrix_arithmetic_macros.svh -----
// ---------------------------------------------------------------------------
// Small matrix arithmetic: assertion macros
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ARITHMETIC_MACROS_SVH
`define SMALL_MATRIX_ARITHMETIC_MACROS_SVH

// cons must hold in the same cycle as ante
`define SMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define SMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sma_pkg.sv -----
// ---------------------------------------------------------------------------
// sma_pkg
// Shared constants, codes, command types and helpers of the matrix unit.
// ---------------------------------------------------------------------------
package sma_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int POS_W     = 8;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LIN_W     = 2 * DIM_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + IDX_W + 1;
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_ROWS  = 2'd1,
    REG_INNER = 2'd2,
    REG_COLS  = 2'd3
  } sma_reg_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_SUB   = 2'd1,
    MODE_MUL   = 2'd2,
    MODE_MUL_T = 2'd3
  } sma_mode_t;

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } sma_state_t;

  typedef struct packed {
    logic mul;
    logic sub;
    logic first;
    logic last_term;
    logic last_result;
  } sma_tag_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    sma_tag_t          tag;
  } sma_cmd_t;

  typedef struct packed {
    logic busy;
  } sma_status_t;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(v);
    end
    return d;
  endfunction

endpackage

// ----- rtl/sma_if.sv -----
// ---------------------------------------------------------------------------
// sma_in_if / sma_out_if
// Valid/ready channels for loaded elements and for result elements.
// ---------------------------------------------------------------------------
interface sma_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface sma_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               is_last;

  modport source (output valid, output result_value, output is_last, input ready);
  modport sink   (input valid, input result_value, input is_last, output ready);
endinterface

// ----- rtl/sma_datapath.sv -----
// ---------------------------------------------------------------------------
// sma_datapath
// Operand stores, multiply/add/subtract stage, exact accumulator, round/saturate and
// the output register.
// ---------------------------------------------------------------------------
`include "small_matrix_arithmetic_macros.svh"

module sma_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sma_pkg::sma_cmd_t          cmd,
  input  logic signed [31:0]         wr_data,
  output sma_pkg::sma_status_t       status,
  sma_out_if.source                  out_ch
);
  import sma_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'((ACC_W'(1) << FRAC_BITS) >> 1);

  logic signed [DATA_W-1:0] mem_a [MEM_DEPTH];
  logic signed [DATA_W-1:0] mem_b [MEM_DEPTH];

  logic signed [DATA_W-1:0] a_q_r, b_q_r;
  logic                     v1_r, v2_r, v3_r;
  sma_tag_t                 tag1_r, tag2_r, tag3_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd, shifted;
  logic [DATA_W-1:0]        sat_val;
  logic [DATA_W-1:0]        out_data_r;
  logic                     out_last_r;
  logic                     out_valid_r;

  // stores and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[cmd.wr_addr] <= wr_data;
    end
    if (cmd.wr_b) begin
      mem_b[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      a_q_r  <= mem_a[cmd.rd_addr_a];
      b_q_r  <= mem_b[cmd.rd_addr_b];
      tag1_r <= cmd.tag;
    end
  end

  always_comb begin
    if (tag1_r.mul) begin
      prod_nxt = PROD_W'(a_q_r) * PROD_W'(b_q_r);
    end else if (tag1_r.sub) begin
      prod_nxt = PROD_W'(a_q_r) - PROD_W'(b_q_r);
    end else begin
      prod_nxt = PROD_W'(a_q_r) + PROD_W'(b_q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= prod_nxt;
      tag2_r <= tag1_r;
    end
    if (v2_r) begin
      acc_r  <= tag2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
      tag3_r <= tag2_r;
    end
  end

  // in multiply modes round half up at the binary point; always clamp to 32 bits
  always_comb begin
    rnd     = acc_r + (tag3_r.mul ? ROUND_HALF : '0);
    shifted = tag3_r.mul ? (rnd >>> FRAC_BITS) : acc_r;
    if ((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1])) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      out_data_r <= sat_val;
      out_last_r <= tag3_r.last_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r && tag2_r.last_term;
      if (v3_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.busy         = v1_r || v2_r || v3_r || out_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_data_r;
  assign out_ch.is_last      = out_last_r;

  `SMA_ASSERT_IMP(a_no_overwrite, v3_r, !out_valid_r, "result register overwritten")
  `SMA_ASSERT_IMP(a_acc_chain, v2_r && !tag2_r.first, $past(v2_r), "accumulation chain broken")
  `SMA_ASSERT_IMP(a_rd_wr_excl, cmd.rd_en, !(cmd.wr_a || cmd.wr_b), "store read during load")

endmodule

// ----- rtl/sma_ctrl.sv -----
// ---------------------------------------------------------------------------
// sma_ctrl
// Configuration registers, load sequencing and the result walk that issues
// store reads to the datapath.
// ---------------------------------------------------------------------------
`include "small_matrix_arithmetic_macros.svh"

module sma_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sma_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [sma_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sma_pkg::sma_status_t            status,
  output sma_pkg::sma_cmd_t               cmd
);
  import sma_pkg::*;

  sma_mode_t         mode_r;
  logic [CFG_W-1:0]  rows_r, inner_r, cols_r;
  sma_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, t_r, t_nxt;

  logic [DIM_W-1:0]  rr, kk, cc, res_cols;
  logic              mul;
  logic [POS_W-1:0]  a_len, b_len, total, pos_eff, pos_inc, b_pos;
  logic [LIN_W-1:0]  lin_a, lin_b;
  logic              term_last, col_last, row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MUL;
      rows_r  <= CFG_W'(8);
      inner_r <= CFG_W'(8);
      cols_r  <= CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= sma_mode_t'(cfg_data[1:0]);
        REG_ROWS:  rows_r  <= cfg_data;
        REG_INNER: inner_r <= cfg_data;
        REG_COLS:  cols_r  <= cfg_data;
      endcase
    end
  end

  assign rr       = eff_dim(rows_r);
  assign kk       = eff_dim(inner_r);
  assign cc       = eff_dim(cols_r);
  assign mul      = (mode_r == MODE_MUL) || (mode_r == MODE_MUL_T);
  assign res_cols = mul ? cc : kk;
  assign a_len    = POS_W'(rr) * POS_W'(kk);
  assign b_len    = mul ? POS_W'(kk) * POS_W'(cc) : a_len;
  assign total    = a_len + b_len;
  assign pos_eff  = (pos_r >= total) ? '0 : pos_r;
  assign pos_inc  = pos_eff + POS_W'(1);
  assign b_pos    = pos_eff - a_len;

  // row-major linear addresses; in add/sub the term index is the column
  always_comb begin
    lin_a = LIN_W'(i_r) * LIN_W'(kk) + LIN_W'(mul ? t_r : j_r);
    case (mode_r)
      MODE_MUL:   lin_b = LIN_W'(t_r) * LIN_W'(cc) + LIN_W'(j_r);
      MODE_MUL_T: lin_b = LIN_W'(j_r) * LIN_W'(kk) + LIN_W'(t_r);
      default:    lin_b = lin_a;
    endcase
  end

  assign term_last = !mul || (DIM_W'(t_r) == kk - DIM_W'(1));
  assign col_last  = DIM_W'(j_r) == res_cols - DIM_W'(1);
  assign row_last  = DIM_W'(i_r) == rr - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      t_r     <= t_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    t_nxt     = t_r;
    in_ready  = 1'b0;

    cmd                 = '0;
    cmd.rd_addr_a       = lin_a[ADDR_W-1:0];
    cmd.rd_addr_b       = lin_b[ADDR_W-1:0];
    cmd.tag.mul         = mul;
    cmd.tag.sub         = (mode_r == MODE_SUB);
    cmd.tag.first       = (t_r == '0);
    cmd.tag.last_term   = term_last;
    cmd.tag.last_result = row_last && col_last;

    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (pos_eff < a_len) begin
            cmd.wr_a    = 1'b1;
            cmd.wr_addr = pos_eff[ADDR_W-1:0];
          end else begin
            cmd.wr_b    = 1'b1;
            cmd.wr_addr = b_pos[ADDR_W-1:0];
          end
          if (pos_inc == total) begin
            pos_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            t_nxt     = '0;
            state_nxt = ST_CALC;
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      ST_CALC: begin
        // a new result starts only once the pipeline and output are empty
        if (t_r != '0 || !status.busy) begin
          cmd.rd_en = 1'b1;
          if (term_last) begin
            t_nxt = '0;
            if (col_last) begin
              j_nxt = '0;
              if (row_last) begin
                i_nxt     = '0;
                state_nxt = ST_LOAD;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            t_nxt = t_r + IDX_W'(1);
          end
        end
      end
    endcase

    // any register write resets the load position
    if (cfg_we) begin
      pos_nxt = '0;
    end
  end

  `SMA_ASSERT_IMP(a_issue_idle, cmd.rd_en && cmd.tag.first, !status.busy, "issue while busy")
  `SMA_ASSERT_IMP(a_pos_in_calc, state_r != ST_LOAD, pos_r == '0, "load position in compute")
  `SMA_ASSERT_NXT(a_back_to_load, cmd.rd_en && cmd.tag.last_result && cmd.tag.last_term,
                  state_r == ST_LOAD, "no return to load after last result")

endmodule

// ----- rtl/small_matrix_arithmetic.sv -----
// ---------------------------------------------------------------------------
// small_matrix_arithmetic
// Loads A then B element by element and streams out A+B, A-B, A*B or A*B^T
// in row-major order, signed Q16.16 with rounding of products and saturation.
// ---------------------------------------------------------------------------
//  channel   dir  payload                       beat accepted when
//  in_ch     in   element[31:0] signed          valid && ready
//  out_ch    out  result_value[31:0], is_last   valid && ready
//  cfg_*     in   cfg_index[1:0], cfg_data[3:0] cfg_we
//
// Loading: in_ch.ready stays high while loading, so every valid beat is taken.
// Compute: each result is made by one store read per term, the multiply
// and accumulate stages and the output register, which must drain before
// the next result starts.
// Reset (rst_n low, synchronous) loads mode 2 and all dimensions 8 and
// restarts loading; store contents are not cleared.
// A stalled out_ch holds the walk; loading of the next pass resumes while
// the final result still waits in the output register.
// ---------------------------------------------------------------------------
module small_matrix_arithmetic (
  input  logic                            clk,
  input  logic                            rst_n,
  sma_in_if.sink                          in_ch,
  sma_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sma_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [sma_pkg::CFG_W-1:0]       cfg_data
);
  import sma_pkg::*;

  sma_cmd_t    cmd;
  sma_status_t status;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  sma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sma_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_data (in_ch.element),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

// ----- bench/tb_small_matrix_arithmetic.sv -----
// ----------------------------------------------------------------------------
// tb_small_matrix_arithmetic
// Streams A and B into the matrix unit under all four modes and a spread of
// dimensions, predicts every result element from an internal fixed-point
// model and checks value and last flag beat by beat, with random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module tb_small_matrix_arithmetic;
  import sma_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 160;
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_MAX    = 10;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] HALF_LSB = 32'sh0000_8000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } matrix_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  sma_in_if  in_ch();
  sma_out_if out_ch();

  small_matrix_arithmetic uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  sma_mode_t          mode_sel;
  logic [CFG_W-1:0]   rows_raw;
  logic [CFG_W-1:0]   inner_raw;
  logic [CFG_W-1:0]   cols_raw;
  logic signed [31:0] a_elems [MEM_DEPTH];
  logic signed [31:0] b_elems [MEM_DEPTH];
  logic [7:0]         fill_pos;

  matrix_result_t pending_results [$];

  int cycle_count;
  int error_count;
  int items_sent;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic signed [31:0] clip_to_word(input logic signed [71:0] x);
    if (x > 72'(WORD_MAX)) return WORD_MAX;
    if (x < 72'(WORD_MIN)) return WORD_MIN;
    return x[31:0];
  endfunction

  function automatic int pass_length();
    int r, k, c;
    r = clamp_dim(rows_raw);
    k = clamp_dim(inner_raw);
    c = clamp_dim(cols_raw);
    if (mode_sel == MODE_MUL || mode_sel == MODE_MUL_T) return r * k + k * c;
    return 2 * r * k;
  endfunction

  function automatic void apply_register(input sma_reg_t idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_MODE:  mode_sel  = sma_mode_t'(data[1:0]);
      REG_ROWS:  rows_raw  = data;
      REG_INNER: inner_raw = data;
      default:   cols_raw  = data;
    endcase
    fill_pos = '0;
  endfunction

  // Stores one element; on the last element of B pushes the whole result.
  function automatic void absorb_element(input logic signed [31:0] v);
    int r, k, c, a_len, total, res_cols, bi;
    logic mul;
    logic signed [32:0] sum33;
    logic signed [71:0] acc;
    matrix_result_t res;
    r = clamp_dim(rows_raw);
    k = clamp_dim(inner_raw);
    c = clamp_dim(cols_raw);
    mul = (mode_sel == MODE_MUL || mode_sel == MODE_MUL_T);
    a_len = r * k;
    total = pass_length();
    if (fill_pos >= total) fill_pos = '0;
    if (fill_pos < a_len) a_elems[fill_pos] = v;
    else b_elems[fill_pos - a_len] = v;
    fill_pos = fill_pos + 8'd1;
    if (fill_pos < total) return;
    fill_pos = '0;
    res_cols = mul ? c : k;
    for (int i = 0; i < r; i++) begin
      for (int j = 0; j < res_cols; j++) begin
        if (!mul) begin
          if (mode_sel == MODE_ADD) sum33 = a_elems[i*k+j] + b_elems[i*k+j];
          else sum33 = a_elems[i*k+j] - b_elems[i*k+j];
          acc = sum33;
          res.value = clip_to_word(acc);
        end else begin
          acc = 72'sd0;
          for (int t = 0; t < k; t++) begin
            bi = (mode_sel == MODE_MUL) ? t * c + j : j * k + t;
            acc = acc + a_elems[i*k+t] * b_elems[bi];
          end
          // round half up, then drop the fraction bits of the product
          acc = (acc + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          res.value = clip_to_word(acc);
        end
        res.last = (i == r - 1) && (j == res_cols - 1);
        pending_results.push_back(res);
      end
    end
  endfunction

  // ------------------------------------------------------------ result side

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("[%0d] %s mismatch: expected %h, got %h", cycle_count, what, want, got);
  endfunction

  always @(posedge clk) begin : result_check
    matrix_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected beat", '0, out_ch.result_value);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_value !== want.value)
          note_mismatch("result_value", want.value, out_ch.result_value);
        if (out_ch.is_last !== want.last)
          note_mismatch("is_last", 32'(want.last), 32'(out_ch.is_last));
      end
    end
  end

  // sink stalls in segments: always ready, coin flip, mostly stalled, periodic
  initial begin : result_sink
    int span;
    int style;
    out_ch.ready <= 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 7) == 0);
          default: out_ch.ready <= (cycle_count % 3 != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------ source side

  task automatic send_element(input logic signed [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.element <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    absorb_element(value);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes the registers picked by mask, once the unit has gone quiet
  task automatic program_block(input logic [3:0] mask, input logic [CFG_W-1:0] mode_v,
                               input logic [CFG_W-1:0] rows_v, input logic [CFG_W-1:0] inner_v,
                               input logic [CFG_W-1:0] cols_v);
    logic [CFG_W-1:0] vals [4];
    sma_reg_t idx;
    vals = '{mode_v, rows_v, inner_v, cols_v};
    drain_results();
    for (int n = 0; n < 4; n++) begin
      if (mask[n]) begin
        idx = sma_reg_t'(n);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= vals[n];
        @(posedge clk);
        apply_register(idx, vals[n]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] random_element();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return 32'sd0;
          3:       return 32'sd1;
          4:       return -32'sd1;
          default: return HALF_LSB;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_dim();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) return CFG_W'($urandom_range(1, 3));
    if (pick < 16) return CFG_W'($urandom_range(4, MAX_DIM));
    if (pick < 18) return '0;
    return CFG_W'($urandom_range(MAX_DIM + 1, 15));
  endfunction

  // ------------------------------------------------------------------ tests

  // power-up settings: 8x8 times 8x8
  task automatic test_reset_defaults();
    int n_items;
    n_items = pass_length();
    repeat (n_items) send_element(random_element());
  endtask

  task automatic test_add_subtract_saturation();
    program_block(4'b1111, CFG_W'(MODE_ADD), 4'd1, 4'd2, 4'd5);
    send_element(WORD_MAX);
    send_element(WORD_MIN);
    send_element(32'sd1);
    send_element(-32'sd1);
    program_block(4'b0001, CFG_W'(MODE_SUB), '0, '0, '0);
    send_element(WORD_MIN);
    send_element(WORD_MAX);
    send_element(32'sd1);
    send_element(-32'sd1);
  endtask

  // zero dimensions act as one; ties round toward plus infinity
  task automatic test_multiply_rounding();
    program_block(4'b1111, CFG_W'(MODE_MUL), 4'd0, 4'd0, 4'd0);
    send_element(WORD_MIN);
    send_element(WORD_MIN);
    send_element(32'sd1);
    send_element(HALF_LSB);
    program_block(4'b0001, CFG_W'(MODE_MUL_T), '0, '0, '0);
    send_element(-32'sd1);
    send_element(HALF_LSB);
    send_element(WORD_MIN);
    send_element(WORD_MAX);
  endtask

  // rows above MAX_DIM act as MAX_DIM
  task automatic test_oversize_dims();
    program_block(4'b1111, CFG_W'(MODE_MUL_T), 4'd12, 4'd1, 4'd1);
    repeat (9) send_element(random_element());
  endtask

  // a register write between A and B drops what was loaded
  task automatic test_reload_on_config();
    program_block(4'b1111, CFG_W'(MODE_ADD), 4'd1, 4'd1, 4'd1);
    send_element(32'sh0001_0000);
    program_block(4'b0100, '0, '0, 4'd1, '0);
    send_element(32'sh0002_0000);
    send_element(32'sh0003_8000);
  endtask

  task automatic test_random_passes();
    int start_count;
    int remaining;
    int total;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      // a third of the passes run back to back on the same settings
      if ($urandom_range(0, 2) != 0)
        program_block(4'($urandom_range(1, 15)), 4'($urandom), random_dim(), random_dim(),
                      random_dim());
      total = pass_length();
      remaining = (fill_pos >= total) ? total : total - fill_pos;
      if (remaining > 1 && $urandom_range(0, 7) == 0)
        remaining = $urandom_range(1, remaining - 1);
      repeat (remaining) send_element(random_element());
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.element <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MODE;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    cycle_count   = 0;
    error_count   = 0;
    items_sent    = 0;
    burst_left    = 0;
    mode_sel      = MODE_MUL;
    rows_raw      = CFG_W'(MAX_DIM);
    inner_raw     = CFG_W'(MAX_DIM);
    cols_raw      = CFG_W'(MAX_DIM);
    fill_pos      = '0;
    for (int n = 0; n < MEM_DEPTH; n++) begin
      a_elems[n] = '0;
      b_elems[n] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_add_subtract_saturation();
    test_multiply_rounding();
    test_oversize_dims();
    test_reload_on_config();
    test_random_passes();

    drain_results();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
